@@ design/rsd_pkg.sv @@
`timescale 1ns / 1ps

package rsd_pkg;

  localparam int CODE_LENGTH = 255;
  localparam int DATA_LENGTH = 223;
  localparam int CORRECTABLE = 16;
  localparam int NSYM        = 2 * CORRECTABLE;
  localparam int NCELL       = NSYM + 1;
  localparam int POS_W       = 8;
  localparam int LEN_W       = $clog2(NSYM + 1);
  localparam int NIDX_W      = $clog2(NSYM);
  localparam int CNT_W       = 5;
  localparam int ROOT_W      = $clog2(CORRECTABLE);

  localparam logic [8:0] GF_POLY = 9'h11D;
  localparam logic [7:0] GF_ONE  = 8'h01;
  localparam logic [7:0] GF_ALPHA = 8'h02;

  localparam logic [1:0] STAT_CLEAN = 2'd0;
  localparam logic [1:0] STAT_FIXED = 2'd1;
  localparam logic [1:0] STAT_FAIL  = 2'd2;

  typedef logic [7:0] gf_t;
  typedef logic [7:0] gf_tab_t [256];

  typedef enum logic [4:0] {
    ST_RECV, ST_CHECK, ST_BM_CLR, ST_BM_LOAD, ST_BM_DISC, ST_BM_FAC, ST_BM_UPD,
    ST_OM_CLR, ST_OM_LOAD, ST_OM_CALC, ST_DEG, ST_CH_RUN, ST_CH_DRAIN, ST_CH_END,
    ST_FIX_RD, ST_FIX_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {SC_HOLD, SC_CLEAR, SC_ACC, SC_ROT} syn_op_t;

  typedef enum logic [2:0] {
    KC_HOLD, KC_INIT, KC_CLRSH, KC_SHIFT, KC_UPD, KC_OMPUSH, KC_MASK, KC_STEP
  } key_op_t;

  typedef struct packed {
    key_op_t op;
    gf_t     f;
    logic    upd;
    logic    swap;
  } key_cmd_t;

  function automatic gf_t gf_mul(gf_t a, gf_t b);
    logic [8:0] x;
    gf_t        r;
    x = {1'b0, a};
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ GF_POLY;
    end
    return r;
  endfunction

  function automatic gf_tab_t gf_exp_build();
    gf_tab_t t;
    gf_t     x;
    x = GF_ONE;
    for (int k = 0; k < 256; k++) begin
      t[k] = x;
      x = gf_mul(x, GF_ALPHA);
    end
    return t;
  endfunction

  localparam gf_tab_t GF_EXP = gf_exp_build();

  function automatic gf_tab_t gf_inv_build();
    gf_tab_t t;
    t[0] = '0;
    for (int k = 0; k < 255; k++) t[GF_EXP[k]] = GF_EXP[(255 - k) % 255];
    return t;
  endfunction

  localparam gf_tab_t GF_INV = gf_inv_build();

endpackage

@@ design/rsd_in_if.sv @@
`timescale 1ns / 1ps

interface rsd_in_if import rsd_pkg::*; ();
  logic valid;
  logic ready;
  gf_t  in_symbol;
  modport source (output valid, output in_symbol, input ready);
  modport sink (input valid, input in_symbol, output ready);
endinterface

@@ design/rsd_out_if.sv @@
`timescale 1ns / 1ps

interface rsd_out_if import rsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             out_valid;
  gf_t              out_symbol;
  logic [POS_W-1:0] out_position;
  logic             out_data;
  logic             out_last;
  logic [1:0]       out_status;
  logic [CNT_W-1:0] out_error_count;
  modport source (output valid, output out_valid, output out_symbol, output out_position,
                  output out_data, output out_last, output out_status,
                  output out_error_count, input ready);
  modport sink (input valid, input out_valid, input out_symbol, input out_position,
                input out_data, input out_last, input out_status,
                input out_error_count, output ready);
endinterface

@@ design/reed_solomon_block_decoder_core.sv @@
// RS(255,223) decoder over GF(256): each accepted symbol returns the same position of the
// previous codeword through an output register, in the next cycle. Symbols enter at one
// per cycle while the output is not stalled, for a whole codeword; input then pauses for
// decoding: a clean codeword goes straight to done, else 32 key-equation steps (load,
// discrepancy, factor, update), 32 evaluator steps and a 255-position root search run.
// Synchronous active-low reset clears control and syndromes; symbol buffers stay undefined.
`timescale 1ns / 1ps

module reed_solomon_block_decoder_core import rsd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  rsd_in_if.sink   in_s,
  rsd_out_if.source out_s
);

  state_t state_r, state_nxt;

  logic [POS_W-1:0]  pos_r;
  logic              have_r;
  logic              sel_r;
  logic [1:0]        blk_st_r;
  logic [CNT_W-1:0]  blk_cnt_r;

  // key equation registers
  logic [LEN_W-1:0]  len_r;
  gf_t               b_r, d_r, f_r;
  logic [NIDX_W-1:0] n_r;

  // root search pipeline and root list
  logic [POS_W-1:0]  ci_r, cp_r;
  logic              v1_r;
  gf_t               ls_r, os_r, ws_r;
  logic [CNT_W-1:0]  nroot_r;
  logic              fail_r;
  logic [POS_W-1:0]  rpos_r [CORRECTABLE];
  gf_t               rval_r [CORRECTABLE];
  logic [ROOT_W-1:0] k_r;

  // output register
  logic              ov_r, ofv_r, odata_r, olast_r, osel_r;
  logic [POS_W-1:0]  opos_r;
  logic [1:0]        ost_r;
  logic [CNT_W-1:0]  ocnt_r;

  logic      in_fire;
  syn_op_t   syn_op;
  key_cmd_t  kcmd;
  gf_t       syn_w  [NSYM];
  gf_t       lam_w  [NCELL];
  gf_t       bsh_w  [NCELL];
  gf_t       sh_w   [NCELL];
  gf_t       om_w   [NCELL];
  gf_t       prod_w [NCELL];
  gf_t       dsum, psum, lsum, osum, wsum;
  logic      any_syn;
  logic      swap;
  logic      deg_ok;
  logic      root_hit;

  // buffers: bank sel_r receives, the other bank emits
  logic             we_b    [2];
  logic             re_b    [2];
  logic [POS_W-1:0] raddr_b [2];
  gf_t              rdata_b [2];
  logic [POS_W-1:0] waddr;
  gf_t              wdata;

  assign in_s.ready = (state_r == ST_RECV) && (!ov_r || out_s.ready);
  assign in_fire    = in_s.valid & in_s.ready;

  // syndrome ring: accumulate during reception, rotate one place per key-equation and evaluator step
  for (genvar i = 0; i < NSYM; i++) begin : g_syn
    rsd_syn_cell u_syn (
      .clk    (clk),
      .rst_n  (rst_n),
      .op     (syn_op),
      .sym    (in_s.in_symbol),
      .step   (GF_EXP[i]),
      .rot_in (syn_w[(i + 1) % NSYM]),
      .acc    (syn_w[i])
    );
  end

  // locator / evaluator chain, one cell per coefficient
  for (genvar j = 0; j < NCELL; j++) begin : g_key
    localparam int AINV_IDX = (255 - j) % 255;
    gf_t lam_prev, bsh_prev, sh_prev, om_in;
    if (j == 0) begin : g_first
      assign lam_prev = '0;
      assign bsh_prev = '0;
      assign sh_prev  = syn_w[0];
    end else begin : g_rest
      assign lam_prev = lam_w[j-1];
      assign bsh_prev = bsh_w[j-1];
      assign sh_prev  = sh_w[j-1];
    end
    if (j == NSYM - 1) begin : g_top
      assign om_in = psum;
    end else if (j == NSYM) begin : g_spare
      assign om_in = '0;
    end else begin : g_mid
      assign om_in = om_w[j+1];
    end
    rsd_key_cell u_key (
      .clk      (clk),
      .cmd      (kcmd),
      .lam_prev (lam_prev),
      .bsh_prev (bsh_prev),
      .sh_prev  (sh_prev),
      .om_in    (om_in),
      .lam_init (j == 0),
      .bsh_init (j == 1),
      .drop     (LEN_W'(j) > len_r),
      .ainv     (GF_EXP[AINV_IDX]),
      .lam      (lam_w[j]),
      .bsh      (bsh_w[j]),
      .sh       (sh_w[j]),
      .om       (om_w[j]),
      .prod     (prod_w[j])
    );
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    rsd_ram #(.WIDTH(8), .DEPTH(CODE_LENGTH)) u_buf (
      .clk   (clk),
      .we    (we_b[b]),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re_b[b]),
      .raddr (raddr_b[b]),
      .rdata (rdata_b[b])
    );
    // receive bank: incoming symbols and corrections; emit bank: output reads
    assign we_b[b] = (sel_r == 1'(b)) &&
                     ((state_r == ST_RECV && in_fire) || state_r == ST_FIX_WR);
    assign re_b[b] = (sel_r == 1'(b)) ? (state_r == ST_FIX_RD) : in_fire;
    assign raddr_b[b] = (sel_r == 1'(b)) ? rpos_r[k_r] : pos_r;
  end

  assign waddr = (state_r == ST_FIX_WR) ? rpos_r[k_r] : pos_r;
  assign wdata = (state_r == ST_FIX_WR) ? (rdata_b[sel_r] ^ rval_r[k_r]) : in_s.in_symbol;

  // reduction trees over the cells
  always_comb begin
    dsum    = '0;
    psum    = '0;
    lsum    = '0;
    osum    = '0;
    wsum    = '0;
    any_syn = 1'b0;
    for (int j = 0; j < NCELL; j++) begin
      psum = psum ^ prod_w[j];
      lsum = lsum ^ lam_w[j];
      if (LEN_W'(j) <= len_r) dsum = dsum ^ prod_w[j];
      if ((j & 1) == 1) osum = osum ^ lam_w[j];
    end
    for (int i = 0; i < NSYM; i++) begin
      wsum    = wsum ^ om_w[i];
      any_syn = any_syn | (syn_w[i] != '0);
    end
  end

  // length change when the discrepancy is nonzero and 2L <= n
  assign swap     = (d_r != '0) && ({1'b0, len_r, 1'b0} <= {3'b0, n_r});
  assign deg_ok   = (len_r != '0) && (len_r <= LEN_W'(CORRECTABLE));
  assign root_hit = v1_r && (ls_r == '0) && !fail_r;

  always_comb begin
    state_nxt = state_r;
    syn_op    = SC_HOLD;
    kcmd.op   = KC_HOLD;
    kcmd.f    = f_r;
    kcmd.upd  = d_r != '0;
    kcmd.swap = swap;
    case (state_r)
      ST_RECV: begin
        if (in_fire) begin
          syn_op = SC_ACC;
          if (pos_r == POS_W'(CODE_LENGTH - 1)) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:   state_nxt = any_syn ? ST_BM_CLR : ST_DONE;
      ST_BM_CLR: begin
        kcmd.op   = KC_INIT;
        state_nxt = ST_BM_LOAD;
      end
      ST_BM_LOAD: begin
        syn_op    = SC_ROT;
        kcmd.op   = KC_SHIFT;
        state_nxt = ST_BM_DISC;
      end
      ST_BM_DISC: state_nxt = ST_BM_FAC;
      ST_BM_FAC:  state_nxt = ST_BM_UPD;
      ST_BM_UPD: begin
        kcmd.op   = KC_UPD;
        state_nxt = (n_r == NIDX_W'(NSYM - 1)) ? ST_OM_CLR : ST_BM_LOAD;
      end
      ST_OM_CLR: begin
        kcmd.op   = KC_CLRSH;
        state_nxt = ST_OM_LOAD;
      end
      ST_OM_LOAD: begin
        syn_op    = SC_ROT;
        kcmd.op   = KC_SHIFT;
        state_nxt = ST_OM_CALC;
      end
      ST_OM_CALC: begin
        kcmd.op   = KC_OMPUSH;
        state_nxt = (n_r == NIDX_W'(NSYM - 1)) ? ST_DEG : ST_OM_LOAD;
      end
      ST_DEG: begin
        if (deg_ok) begin
          kcmd.op   = KC_MASK;
          state_nxt = ST_CH_RUN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CH_RUN: begin
        kcmd.op = KC_STEP;
        if (ci_r == POS_W'(CODE_LENGTH - 1)) state_nxt = ST_CH_DRAIN;
      end
      ST_CH_DRAIN: state_nxt = ST_CH_END;
      ST_CH_END: begin
        if (fail_r || (nroot_r != CNT_W'(len_r))) state_nxt = ST_DONE;
        else state_nxt = ST_FIX_RD;
      end
      ST_FIX_RD: state_nxt = ST_FIX_WR;
      ST_FIX_WR: begin
        state_nxt = ((CNT_W'(k_r) + 1'b1) == nroot_r) ? ST_DONE : ST_FIX_RD;
      end
      ST_DONE: begin
        syn_op    = SC_CLEAR;
        state_nxt = ST_RECV;
      end
      default: state_nxt = ST_RECV;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RECV;
      pos_r     <= '0;
      have_r    <= 1'b0;
      sel_r     <= 1'b0;
      blk_st_r  <= STAT_CLEAN;
      blk_cnt_r <= '0;
      ov_r      <= 1'b0;
      v1_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_CH_RUN);
      if (in_fire) ov_r <= 1'b1;
      else if (out_s.ready) ov_r <= 1'b0;
      if (in_fire) begin
        pos_r <= (pos_r == POS_W'(CODE_LENGTH - 1)) ? '0 : pos_r + 1'b1;
      end
      case (state_r)
        ST_CHECK: begin
          if (!any_syn) begin
            blk_st_r  <= STAT_CLEAN;
            blk_cnt_r <= '0;
          end
        end
        ST_DEG: begin
          if (!deg_ok) begin
            blk_st_r  <= STAT_FAIL;
            blk_cnt_r <= '0;
          end
        end
        ST_CH_END: begin
          if (fail_r || (nroot_r != CNT_W'(len_r))) begin
            blk_st_r  <= STAT_FAIL;
            blk_cnt_r <= '0;
          end else begin
            blk_st_r  <= STAT_FIXED;
            blk_cnt_r <= nroot_r;
          end
        end
        ST_DONE: begin
          sel_r  <= ~sel_r;
          have_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_BM_CLR: begin
        len_r <= '0;
        b_r   <= GF_ONE;
        n_r   <= '0;
      end
      ST_BM_DISC: d_r <= dsum;
      ST_BM_FAC:  f_r <= gf_mul(d_r, GF_INV[b_r]);
      ST_BM_UPD: begin
        if (swap) begin
          len_r <= LEN_W'(n_r) + 1'b1 - len_r;
          b_r   <= d_r;
        end
        n_r <= n_r + 1'b1;
      end
      ST_OM_CALC: n_r <= n_r + 1'b1;
      ST_DEG: begin
        ci_r    <= '0;
        nroot_r <= '0;
        fail_r  <= 1'b0;
      end
      ST_CH_RUN: ci_r <= ci_r + 1'b1;
      ST_CH_END: k_r <= '0;
      ST_FIX_WR: k_r <= k_r + 1'b1;
      default: ;
    endcase

    // first stage of the root search: register the sums of the current position
    ls_r <= lsum;
    os_r <= osum;
    ws_r <= wsum;
    cp_r <= ci_r;

    // second stage: count roots, record position and error value, or flag failure
    if (root_hit) begin
      if ((CNT_W'(nroot_r) >= CNT_W'(len_r)) || (os_r == '0)) begin
        fail_r <= 1'b1;
      end else begin
        rpos_r[nroot_r[ROOT_W-1:0]] <= cp_r;
        rval_r[nroot_r[ROOT_W-1:0]] <= gf_mul(ws_r, GF_INV[os_r]);
        nroot_r <= nroot_r + 1'b1;
      end
    end

    // output payload, captured with each request
    if (in_fire) begin
      ofv_r   <= have_r;
      osel_r  <= ~sel_r;
      opos_r  <= have_r ? pos_r : '0;
      odata_r <= have_r && (pos_r < POS_W'(DATA_LENGTH));
      olast_r <= have_r && (pos_r == POS_W'(CODE_LENGTH - 1));
      ost_r   <= have_r ? blk_st_r : STAT_CLEAN;
      ocnt_r  <= have_r ? blk_cnt_r : '0;
    end
  end

  assign out_s.valid           = ov_r;
  assign out_s.out_valid       = ofv_r;
  assign out_s.out_symbol      = ofv_r ? rdata_b[osel_r] : '0;
  assign out_s.out_position    = opos_r;
  assign out_s.out_data        = odata_r;
  assign out_s.out_last        = olast_r;
  assign out_s.out_status      = ost_r;
  assign out_s.out_error_count = ocnt_r;

endmodule

@@ design/rsd_ram.sv @@
`timescale 1ns / 1ps

module rsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/rsd_syn_cell.sv @@
`timescale 1ns / 1ps

module rsd_syn_cell import rsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  syn_op_t op,
  input  gf_t     sym,
  input  gf_t     step,
  input  gf_t     rot_in,
  output gf_t     acc
);

  gf_t acc_r, acc_nxt;
  gf_t pw_r, pw_nxt;

  always_comb begin
    acc_nxt = acc_r;
    pw_nxt  = pw_r;
    case (op)
      SC_CLEAR: begin
        acc_nxt = '0;
        pw_nxt  = GF_ONE;
      end
      SC_ACC: begin
        acc_nxt = acc_r ^ gf_mul(sym, pw_r);
        pw_nxt  = gf_mul(pw_r, step);
      end
      SC_ROT:  acc_nxt = rot_in;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pw_r  <= GF_ONE;
    end else begin
      acc_r <= acc_nxt;
      pw_r  <= pw_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ design/rsd_key_cell.sv @@
`timescale 1ns / 1ps

module rsd_key_cell import rsd_pkg::*; (
  input  logic     clk,
  input  key_cmd_t cmd,
  input  gf_t      lam_prev,
  input  gf_t      bsh_prev,
  input  gf_t      sh_prev,
  input  gf_t      om_in,
  input  logic     lam_init,
  input  logic     bsh_init,
  input  logic     drop,
  input  gf_t      ainv,
  output gf_t      lam,
  output gf_t      bsh,
  output gf_t      sh,
  output gf_t      om,
  output gf_t      prod
);

  gf_t lam_r, lam_nxt;
  gf_t bsh_r, bsh_nxt;
  gf_t sh_r, sh_nxt;
  gf_t om_r, om_nxt;

  always_comb begin
    lam_nxt = lam_r;
    bsh_nxt = bsh_r;
    sh_nxt  = sh_r;
    om_nxt  = om_r;
    case (cmd.op)
      KC_INIT: begin
        lam_nxt = lam_init ? GF_ONE : '0;
        bsh_nxt = bsh_init ? GF_ONE : '0;
        sh_nxt  = '0;
      end
      KC_CLRSH: sh_nxt = '0;
      KC_SHIFT: sh_nxt = sh_prev;
      KC_UPD: begin
        if (cmd.upd) lam_nxt = lam_r ^ gf_mul(cmd.f, bsh_r);
        bsh_nxt = cmd.swap ? lam_prev : bsh_prev;
      end
      KC_OMPUSH: om_nxt = om_in;
      KC_MASK: begin
        if (drop) lam_nxt = '0;
      end
      KC_STEP: begin
        lam_nxt = gf_mul(lam_r, ainv);
        om_nxt  = gf_mul(om_r, ainv);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lam_r <= lam_nxt;
    bsh_r <= bsh_nxt;
    sh_r  <= sh_nxt;
    om_r  <= om_nxt;
  end

  assign lam  = lam_r;
  assign bsh  = bsh_r;
  assign sh   = sh_r;
  assign om   = om_r;
  assign prod = gf_mul(lam_r, sh_r);

endmodule
